// ===== rtl/rv64alu_pkg.sv =====
// Shared types and opcode/funct3 codes for the RV64I ALU and branch unit.
package rv64alu_pkg;

    localparam int unsigned XLEN = 64;

    // Major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    // ALU funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct7 bit that selects SUB / SRA, immediate bit that selects SRAI
    localparam int unsigned F7_ALT_BIT  = 5;
    localparam int unsigned IMM_SRA_BIT = 10;

    localparam logic [XLEN-1:0] INSTR_BYTES = 64'd4;

    // One issued instruction
    typedef struct packed {
        logic [6:0]      kind;
        logic [2:0]      func_low;
        logic [6:0]      func_high;
        logic [XLEN-1:0] source_a;
        logic [XLEN-1:0] source_b;
        logic [XLEN-1:0] immediate;
        logic [XLEN-1:0] instr_pc;
        logic [4:0]      dest_in;
    } req_t;

    // Control-flow outcome
    typedef struct packed {
        logic            taken;
        logic [XLEN-1:0] target_pc;
    } flow_t;

    // One result
    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic            taken;
        logic [XLEN-1:0] target_pc;
        logic [4:0]      dest_out;
    } res_t;

endpackage

// ===== rtl/rv64alu_exec.sv =====
// Register-result datapath: LUI, AUIPC, OP, OP-IMM and link value of jumps.
module rv64alu_exec (
    input  rv64alu_pkg::req_t         req,
    output logic [rv64alu_pkg::XLEN-1:0] value
);
    import rv64alu_pkg::*;

    logic            is_imm;
    logic            alt;
    logic [XLEN-1:0] op2;
    logic [5:0]      shamt;
    logic [XLEN-1:0] alu_out;

    // Operand select and alternate-op decode
    assign is_imm = (req.kind == OPC_OP_IMM);
    assign op2    = is_imm ? req.immediate : req.source_b;
    assign shamt  = op2[5:0];
    assign alt    = is_imm ? req.immediate[IMM_SRA_BIT] : req.func_high[F7_ALT_BIT];

    // ALU
    always_comb begin
        case (req.func_low)
            F3_ADD:  alu_out = (!is_imm && alt) ? req.source_a - op2 : req.source_a + op2;
            F3_SLL:  alu_out = req.source_a << shamt;
            F3_SLT:  alu_out = {{(XLEN-1){1'b0}},
                                ($signed(req.source_a) < $signed(op2))};
            F3_SLTU: alu_out = {{(XLEN-1){1'b0}}, (req.source_a < op2)};
            F3_XOR:  alu_out = req.source_a ^ op2;
            F3_SR:   alu_out = alt ? XLEN'($signed(req.source_a) >>> shamt)
                                   : req.source_a >> shamt;
            F3_OR:   alu_out = req.source_a | op2;
            default: alu_out = req.source_a & op2;
        endcase
    end

    // Result select by major opcode
    always_comb begin
        unique case (req.kind) inside
            OPC_LUI:             value = req.immediate;
            OPC_AUIPC:           value = req.instr_pc + req.immediate;
            OPC_OP, OPC_OP_IMM:  value = alu_out;
            OPC_JAL, OPC_JALR:   value = req.instr_pc + INSTR_BYTES;
            default:             value = '0;
        endcase
    end

endmodule

// ===== rtl/rv64alu_branch.sv =====
// Jump and branch resolution: taken flag and next pc.
module rv64alu_branch (
    input  rv64alu_pkg::req_t  req,
    output rv64alu_pkg::flow_t flow
);
    import rv64alu_pkg::*;

    logic            cond;
    logic            lt_s;
    logic            lt_u;
    logic            eq;
    logic [XLEN-1:0] link;
    logic [XLEN-1:0] pc_rel;
    logic [XLEN-1:0] reg_rel;

    assign eq      = (req.source_a == req.source_b);
    assign lt_s    = ($signed(req.source_a) < $signed(req.source_b));
    assign lt_u    = (req.source_a < req.source_b);
    assign link    = req.instr_pc + INSTR_BYTES;
    assign pc_rel  = req.instr_pc + req.immediate;
    assign reg_rel = req.source_a + req.immediate;

    // Branch condition
    always_comb begin
        unique case (req.func_low)
            F3_BEQ:  cond = eq;
            F3_BNE:  cond = !eq;
            F3_BLT:  cond = lt_s;
            F3_BGE:  cond = !lt_s;
            F3_BLTU: cond = lt_u;
            F3_BGEU: cond = !lt_u;
            default: cond = 1'b0;
        endcase
    end

    // Next pc
    always_comb begin
        flow.taken     = 1'b0;
        flow.target_pc = link;
        unique case (req.kind)
            OPC_JAL: begin
                flow.taken     = 1'b1;
                flow.target_pc = pc_rel;
            end
            OPC_JALR: begin
                flow.taken     = 1'b1;
                flow.target_pc = {reg_rel[XLEN-1:1], 1'b0};
            end
            OPC_BRANCH: begin
                flow.taken     = cond;
                flow.target_pc = cond ? pc_rel : link;
            end
            default: begin
                flow.taken     = 1'b0;
                flow.target_pc = link;
            end
        endcase
    end

endmodule

// ===== rtl/rv64_integer_alu_and_branch_unit_top.sv =====
// RV64I integer ALU and branch unit, two-stage pipeline: one instruction request per clock
// unless m_tready stalls. A request is taken into an input register, resolved by one level
// of adders, a comparator and a 64-bit barrel shifter, and lands in the result register,
// which drives m_tvalid; the unit accepts a new request every cycle as long as the result
// side keeps taking results. A stall on m_tready backs up through the two registers;
// s_tready drops only when both hold a request. Unknown opcodes (loads, stores, W forms)
// return zero, not taken, pc+4.
module rv64_integer_alu_and_branch_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // func_low[2:0], func_high[9:3], source_a[73:10], source_b[137:74],
    // immediate[201:138], instr_pc[265:202], dest_in[270:266], zero[271]
    input  logic [271:0] s_tdata,
    // kind[6:0]
    input  logic [6:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_value[63:0], taken[64], target_pc[128:65], dest_out[133:129],
    // zero[135:134]
    output logic [135:0] m_tdata
);
    import rv64alu_pkg::*;

    logic  s1_valid_reg;
    logic  s1_valid_next;
    req_t  s1_req_reg;
    logic  m_valid_reg;
    logic  m_valid_next;
    res_t  m_res_reg;
    res_t  res_next;
    logic  out_adv;
    logic  in_take;
    flow_t flow;
    logic [XLEN-1:0] value;

    // Pipeline flow control
    assign out_adv  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_adv;
    assign in_take  = s_tvalid && s_tready;

    assign s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;
    assign m_valid_next  = out_adv ? s1_valid_reg : m_valid_reg;

    // Datapath
    rv64alu_exec u_exec (
        .req   (s1_req_reg),
        .value (value)
    );

    rv64alu_branch u_branch (
        .req  (s1_req_reg),
        .flow (flow)
    );

    assign res_next.result_value = value;
    assign res_next.taken        = flow.taken;
    assign res_next.target_pc    = flow.target_pc;
    assign res_next.dest_out     = s1_req_reg.dest_in;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (in_take) begin
            s1_req_reg.kind      <= s_tuser;
            s1_req_reg.func_low  <= s_tdata[2:0];
            s1_req_reg.func_high <= s_tdata[9:3];
            s1_req_reg.source_a  <= s_tdata[73:10];
            s1_req_reg.source_b  <= s_tdata[137:74];
            s1_req_reg.immediate <= s_tdata[201:138];
            s1_req_reg.instr_pc  <= s_tdata[265:202];
            s1_req_reg.dest_in   <= s_tdata[270:266];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.dest_out, m_res_reg.target_pc,
                       m_res_reg.taken, m_res_reg.result_value};

`ifndef NO_ASSERTIONS
    // A request in the input stage is never dropped while the result side stalls
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_adv) |=> s1_valid_reg)
        else $error("input stage lost a request during a stall");

    // A not-taken result always carries the fall-through pc
    a_fallthrough: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_adv && !res_next.taken)
            |=> (m_res_reg.target_pc == $past(s1_req_reg.instr_pc) + INSTR_BYTES))
        else $error("not-taken result without pc+4 target");

    // Conditional branches write no register value
    a_branch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_adv && (s1_req_reg.kind == OPC_BRANCH))
            |=> (m_res_reg.result_value == '0))
        else $error("branch produced a nonzero register value");
`endif

endmodule
